// ----- hdl/rtcdc_pkg.sv -----
// ----------------------------------------------------------------------------
// RTC BCD date/time decode package
// Shared types, field limits and helper functions for the clock snapshot
// decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcdc_pkg;

    // Result status codes; the fourth code is never produced.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_READ_FAIL = 2'd2
    } status_t;

    // Field widths.
    localparam int unsigned BCD_W     = 8;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned WEEKDAY_W = 3;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MINUTE_W  = 6;
    localparam int unsigned SECOND_W  = 6;
    localparam int unsigned VALUE_W   = 7;   // binary value of two BCD digits, 0..99

    // Stream widths.
    localparam int unsigned S_TDATA_W = 7 * BCD_W;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_USED_W  = YEAR_W + MONTH_W + DAY_W + WEEKDAY_W
                                        + HOUR_W + MINUTE_W + SECOND_W;

    // Decoded field limits.
    localparam logic [VALUE_W-1:0] YEAR_MAX    = 7'd99;
    localparam logic [VALUE_W-1:0] MONTH_MAX   = 7'd12;
    localparam logic [VALUE_W-1:0] DAY_MAX     = 7'd31;
    localparam logic [VALUE_W-1:0] WEEKDAY_MAX = 7'd6;
    localparam logic [VALUE_W-1:0] HOUR_MAX    = 7'd23;
    localparam logic [VALUE_W-1:0] MINUTE_MAX  = 7'd59;
    localparam logic [VALUE_W-1:0] SECOND_MAX  = 7'd59;

    localparam logic [YEAR_W-1:0]  YEAR_BASE   = 12'd2000;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    // One decoded result as it leaves the decoder.
    typedef struct packed {
        status_t                status;
        logic [YEAR_W-1:0]      full_year;
        logic [MONTH_W-1:0]     month_out;
        logic [DAY_W-1:0]       day_out;
        logic [WEEKDAY_W-1:0]   weekday_out;
        logic [HOUR_W-1:0]      hour_out;
        logic [MINUTE_W-1:0]    minute_out;
        logic [SECOND_W-1:0]    second_out;
    } result_t;

    // True when both nibbles are decimal digits.
    function automatic logic bcd_digits_ok(input logic [BCD_W-1:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    // Binary value of a BCD byte: tens * 10 + units, built from shifts.
    function automatic logic [VALUE_W-1:0] bcd_value(input logic [BCD_W-1:0] b);
        logic [VALUE_W-1:0] tens;
        tens = {3'b000, b[7:4]};
        return (tens << 3) + (tens << 1) + {3'b000, b[3:0]};
    endfunction

    // Days in a month for a non-leap year; codes outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo);
        logic [DAY_W-1:0] d;
        unique case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rtcdc_decode.sv -----
// ----------------------------------------------------------------------------
// RTC BCD snapshot decoder
// Checks the seven BCD bytes of one snapshot against their digit rules and
// field limits, checks the day against the month length and builds the
// status and decoded fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcdc_decode (
    input  wire logic                           read_failed,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    year_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    month_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    day_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    weekday_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    hour_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    minute_bcd,
    input  wire logic [rtcdc_pkg::BCD_W-1:0]    second_bcd,
    output rtcdc_pkg::result_t                  result
);

    logic [rtcdc_pkg::VALUE_W-1:0] yr, mo, dy, wd, hr, mi, se;
    logic                          digits_ok;
    logic                          limits_ok;
    logic                          leap;
    logic [rtcdc_pkg::DAY_W-1:0]   day_limit;
    logic                          date_ok;
    logic [rtcdc_pkg::YEAR_W-1:0]  full_year;

    // Binary values of every byte.
    assign yr = rtcdc_pkg::bcd_value(year_bcd);
    assign mo = rtcdc_pkg::bcd_value(month_bcd);
    assign dy = rtcdc_pkg::bcd_value(day_bcd);
    assign wd = rtcdc_pkg::bcd_value(weekday_bcd);
    assign hr = rtcdc_pkg::bcd_value(hour_bcd);
    assign mi = rtcdc_pkg::bcd_value(minute_bcd);
    assign se = rtcdc_pkg::bcd_value(second_bcd);

    // Every nibble must be a decimal digit.
    assign digits_ok = rtcdc_pkg::bcd_digits_ok(year_bcd)
                     & rtcdc_pkg::bcd_digits_ok(month_bcd)
                     & rtcdc_pkg::bcd_digits_ok(day_bcd)
                     & rtcdc_pkg::bcd_digits_ok(weekday_bcd)
                     & rtcdc_pkg::bcd_digits_ok(hour_bcd)
                     & rtcdc_pkg::bcd_digits_ok(minute_bcd)
                     & rtcdc_pkg::bcd_digits_ok(second_bcd);

    // Upper field limits; month and day lower bounds follow below.
    assign limits_ok = (yr <= rtcdc_pkg::YEAR_MAX)
                     & (mo <= rtcdc_pkg::MONTH_MAX)
                     & (dy <= rtcdc_pkg::DAY_MAX)
                     & (wd <= rtcdc_pkg::WEEKDAY_MAX)
                     & (hr <= rtcdc_pkg::HOUR_MAX)
                     & (mi <= rtcdc_pkg::MINUTE_MAX)
                     & (se <= rtcdc_pkg::SECOND_MAX);

    assign full_year = rtcdc_pkg::YEAR_BASE + {5'b00000, yr};

    // The years 2000..2099 are leap years exactly when divisible by four:
    // 2000 is the only century in range and it is divisible by 400.
    assign leap = (full_year[1:0] == 2'b00);

    // Month length with the February leap day added.
    always_comb begin
        day_limit = rtcdc_pkg::month_days(mo[rtcdc_pkg::MONTH_W-1:0]);
        if ((mo[rtcdc_pkg::MONTH_W-1:0] == rtcdc_pkg::MONTH_FEB) && leap) begin
            day_limit = day_limit + 5'd1;
        end
    end

    assign date_ok = (mo != '0)
                   && (mo <= {3'b000, rtcdc_pkg::MONTH_DEC})
                   && (dy != '0)
                   && (dy[rtcdc_pkg::DAY_W-1:0] <= day_limit);

    // Status and fields; fields stay zero unless the snapshot is good.
    always_comb begin
        result = '0;
        priority if (read_failed) begin
            result.status = rtcdc_pkg::STATUS_READ_FAIL;
        end else if (digits_ok && limits_ok && date_ok) begin
            result.status      = rtcdc_pkg::STATUS_OK;
            result.full_year   = full_year;
            result.month_out   = mo[rtcdc_pkg::MONTH_W-1:0];
            result.day_out     = dy[rtcdc_pkg::DAY_W-1:0];
            result.weekday_out = wd[rtcdc_pkg::WEEKDAY_W-1:0];
            result.hour_out    = hr[rtcdc_pkg::HOUR_W-1:0];
            result.minute_out  = mi[rtcdc_pkg::MINUTE_W-1:0];
            result.second_out  = se[rtcdc_pkg::SECOND_W-1:0];
        end else begin
            result.status = rtcdc_pkg::STATUS_INVALID;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rtc_bcd_datetime_decode_check_unit.sv -----
// Path: a request is held in the input register and its decoded result in the result register.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that advances whenever the result
// register is free or being read.
// Reset: aresetn low clears both stage valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// RTC BCD date/time decode and check unit
// Stream front end for the clock snapshot decoder: input register, decode
// logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_bcd_datetime_decode_check_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Request channel.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // year_bcd, month_bcd, day_bcd, weekday_bcd, hour_bcd, minute_bcd, second_bcd
    input  wire logic [rtcdc_pkg::S_TDATA_W-1:0]    s_tdata,
    // read_failed
    input  wire logic                               s_tuser,
    // Result channel.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // full_year, month_out, day_out, weekday_out, hour_out, minute_out,
    // second_out, then zero fill
    output logic [rtcdc_pkg::M_TDATA_W-1:0]         m_tdata,
    // status
    output logic [1:0]                              m_tuser
);

    logic                                in_valid_reg, in_valid_next;
    logic [rtcdc_pkg::S_TDATA_W-1:0]     in_data_reg;
    logic                                in_fail_reg;
    logic                                out_valid_reg, out_valid_next;
    rtcdc_pkg::result_t                  out_result_reg;
    rtcdc_pkg::result_t                  dec_result;
    logic                                out_ready;

    // Pipeline flow control.
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next  = s_tready  ? s_tvalid     : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_fail_reg <= s_tuser;
        end
    end

    rtcdc_decode u_decode (
        .read_failed (in_fail_reg),
        .year_bcd    (in_data_reg[7:0]),
        .month_bcd   (in_data_reg[15:8]),
        .day_bcd     (in_data_reg[23:16]),
        .weekday_bcd (in_data_reg[31:24]),
        .hour_bcd    (in_data_reg[39:32]),
        .minute_bcd  (in_data_reg[47:40]),
        .second_bcd  (in_data_reg[55:48]),
        .result      (dec_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_ready) begin
            out_result_reg <= dec_result;
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {
        {(rtcdc_pkg::M_TDATA_W - rtcdc_pkg::M_USED_W){1'b0}},
        out_result_reg.second_out,
        out_result_reg.minute_out,
        out_result_reg.hour_out,
        out_result_reg.weekday_out,
        out_result_reg.day_out,
        out_result_reg.month_out,
        out_result_reg.full_year
    };

endmodule

`default_nettype wire

// ----- hdl/rtcdc_checker.sv -----
// ----------------------------------------------------------------------------
// RTC BCD decode unit port checker
// Watches the top-level ports for reset, status coding, result field
// consistency and the holding of stalled results.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcdc_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [rtcdc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic [1:0]                         m_tuser
);

    // No result is offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The unused status code never appears.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == rtcdc_pkg::STATUS_OK
                   || m_tuser == rtcdc_pkg::STATUS_INVALID
                   || m_tuser == rtcdc_pkg::STATUS_READ_FAIL))
        else $error("reserved status code on result");

    // Failed or invalid snapshots carry all-zero fields.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != rtcdc_pkg::STATUS_OK) |-> (m_tdata == '0))
        else $error("nonzero fields on a failed result");

    // A good result has a real month, a nonzero day and a year in range.
    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == rtcdc_pkg::STATUS_OK) |->
            (m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12
             && m_tdata[20:16] != 5'd0
             && m_tdata[11:0] >= 12'd2000 && m_tdata[11:0] <= 12'd2099))
        else $error("out of range field on a good result");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind rtc_bcd_datetime_decode_check_unit rtcdc_checker u_rtcdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
